// ===== src/bpfr_pkg.sv =====
`default_nettype none
package bpfr_pkg;
	typedef enum logic [1:0] {
		FUNC_PIN   = 2'd0,
		FUNC_UNPIN = 2'd1,
		FUNC_DIRTY = 2'd2,
		FUNC_FLUSH = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOT_HERE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_FLUSH,
		S_EMIT
	} state_t;

	localparam logic CFG_POLICY = 1'b0;
	localparam logic CFG_FRAMES = 1'b1;

	typedef struct packed {
		logic start;
		logic step;
		logic apply;
		logic flush_step;
		logic flush_none;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic flush_hit;
		logic flush_done;
	} sts_t;
endpackage
`default_nettype wire

// ===== src/bpfr_ctrl.sv =====
`default_nettype none
module bpfr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_go,
	input  wire logic          is_flush,
	input  wire logic          out_free,
	input  wire bpfr_pkg::sts_t sts,
	output bpfr_pkg::cmd_t     cmd,
	output logic               busy
);
	bpfr_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= bpfr_pkg::S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bpfr_pkg::S_IDLE: begin
				if (in_go) state_d = is_flush ? bpfr_pkg::S_FLUSH : bpfr_pkg::S_SCAN;
			end
			bpfr_pkg::S_SCAN: begin
				if (sts.scan_done) state_d = bpfr_pkg::S_DECIDE;
			end
			bpfr_pkg::S_DECIDE: begin
				if (out_free) state_d = bpfr_pkg::S_EMIT;
			end
			bpfr_pkg::S_FLUSH: begin
				if (sts.flush_done && out_free) state_d = bpfr_pkg::S_EMIT;
			end
			bpfr_pkg::S_EMIT: state_d = bpfr_pkg::S_IDLE;
			default: state_d = bpfr_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			bpfr_pkg::S_IDLE: begin
				busy = 1'b0;
				cmd.start = in_go;
			end
			bpfr_pkg::S_SCAN: cmd.step = 1'b1;
			bpfr_pkg::S_DECIDE: cmd.apply = out_free;
			bpfr_pkg::S_FLUSH: begin
				cmd.flush_step = out_free;
				cmd.flush_none = sts.flush_done && out_free;
			end
			bpfr_pkg::S_EMIT: busy = 1'b1;
			default: busy = 1'b1;
		endcase
	end
endmodule
`default_nettype wire

// ===== src/bpfr_dp.sv =====
`default_nettype none
module bpfr_dp #(
	parameter int FRAMES   = 16,
	parameter int PIN_BITS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire bpfr_pkg::cmd_t cmd,
	input  wire logic [1:0]     in_func,
	input  wire logic [30:0]    in_page,
	input  wire logic           policy_mode,
	input  wire logic [4:0]     frames_in_use,
	output bpfr_pkg::sts_t      sts,
	output logic                o_push,
	output logic [1:0]          o_status,
	output logic [3:0]          o_frame,
	output logic                o_load,
	output logic                o_wb,
	output logic [30:0]         o_wpage,
	output logic [31:0]         o_reads,
	output logic [31:0]         o_writes,
	output logic                o_last
);
	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CW = $clog2(FRAMES + 1);
	localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

	logic [30:0]         page_q [FRAMES];
	logic [FRAMES-1:0]   valid_q;
	logic [PIN_BITS-1:0] pin_q [FRAMES];
	logic [FRAMES-1:0]   dirty_q;
	logic [31:0]         stamp_q [FRAMES];
	logic [31:0]         ctr_q, reads_q, writes_q;

	logic [1:0]  func_q;
	logic [30:0] pg_q;
	logic [CW-1:0] idx_q, n_q;
	logic hit_f_q, empty_f_q, vic_f_q;
	logic [IW-1:0] hit_q, empty_q, vic_q;
	logic [31:0] best_q;
	logic pend_q;
	logic [IW-1:0] pend_i_q;

	logic [IW-1:0] cur;
	assign cur = idx_q[IW-1:0];
	logic scan_end;
	assign scan_end = (idx_q >= n_q);
	logic cur_hit, cur_dflush;
	assign cur_hit = !scan_end && valid_q[cur] && page_q[cur] == pg_q;
	assign cur_dflush = !scan_end && valid_q[cur] && dirty_q[cur] && pin_q[cur] == '0;
	assign sts.scan_done = scan_end || hit_f_q;
	assign sts.flush_hit = cur_dflush;
	assign sts.flush_done = scan_end;

	assign o_push = cmd.apply || cmd.flush_none || (cmd.flush_step && cur_dflush && pend_q);

	logic [31:0] ctr_inc;
	assign ctr_inc = (ctr_q == 32'hFFFF_FFFF) ? ctr_q : ctr_q + 32'd1;

	logic [IW-1:0] tgt;
	logic do_fill;
	always_comb begin
		do_fill = 1'b0;
		tgt = empty_q;
		if (empty_f_q) do_fill = 1'b1;
		else if (vic_f_q) begin
			do_fill = 1'b1;
			tgt = vic_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			for (int i = 0; i < FRAMES; i++) pin_q[i] <= '0;
			ctr_q <= '0;
			reads_q <= '0;
			writes_q <= '0;
			idx_q <= '0;
			n_q <= '0;
			pend_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				func_q <= in_func;
				pg_q <= in_page;
				idx_q <= '0;
				n_q <= (int'(frames_in_use) > FRAMES) ? CW'(FRAMES) : CW'(frames_in_use);
				hit_f_q <= 1'b0;
				empty_f_q <= 1'b0;
				vic_f_q <= 1'b0;
				pend_q <= 1'b0;
			end
			if (cmd.step && !sts.scan_done) begin
				idx_q <= idx_q + 1'b1;
				if (cur_hit) begin
					hit_f_q <= 1'b1;
					hit_q <= cur;
				end
				if (!valid_q[cur] && !empty_f_q) begin
					empty_f_q <= 1'b1;
					empty_q <= cur;
				end
				if (pin_q[cur] == '0 && (!vic_f_q || stamp_q[cur] <= best_q)) begin
					vic_f_q <= 1'b1;
					vic_q <= cur;
					best_q <= stamp_q[cur];
				end
			end
			if (cmd.apply) begin
				o_last <= 1'b1;
				o_load <= 1'b0;
				o_wb <= 1'b0;
				o_wpage <= '0;
				o_frame <= '0;
				o_status <= bpfr_pkg::ST_OK;
				o_reads <= reads_q;
				o_writes <= writes_q;
				if (func_q == bpfr_pkg::FUNC_PIN) begin
					if (hit_f_q) begin
						o_frame <= 4'(hit_q);
						if (pin_q[hit_q] != PIN_MAX) pin_q[hit_q] <= pin_q[hit_q] + 1'b1;
						if (policy_mode) begin
							stamp_q[hit_q] <= ctr_q;
							ctr_q <= ctr_inc;
						end
					end else if (do_fill) begin
						o_frame <= 4'(tgt);
						o_load <= 1'b1;
						page_q[tgt] <= pg_q;
						valid_q[tgt] <= 1'b1;
						pin_q[tgt] <= PIN_BITS'(1);
						dirty_q[tgt] <= 1'b0;
						stamp_q[tgt] <= ctr_q;
						ctr_q <= ctr_inc;
						reads_q <= reads_q + 32'd1;
						o_reads <= reads_q + 32'd1;
						if (!empty_f_q && dirty_q[tgt]) begin
							o_wb <= 1'b1;
							o_wpage <= page_q[tgt];
							writes_q <= writes_q + 32'd1;
							o_writes <= writes_q + 32'd1;
						end
					end else begin
						o_status <= bpfr_pkg::ST_FULL;
					end
				end else if (!hit_f_q) begin
					o_status <= bpfr_pkg::ST_NOT_HERE;
				end else begin
					o_frame <= 4'(hit_q);
					if (func_q == bpfr_pkg::FUNC_UNPIN) begin
						if (pin_q[hit_q] != '0) pin_q[hit_q] <= pin_q[hit_q] - 1'b1;
					end else begin
						dirty_q[hit_q] <= 1'b1;
					end
				end
			end
			// flush: hold one found frame back so the final one carries last
			if (cmd.flush_step && !scan_end) begin
				idx_q <= idx_q + 1'b1;
				if (cur_dflush) begin
					dirty_q[cur] <= 1'b0;
					writes_q <= writes_q + 32'd1;
					pend_q <= 1'b1;
					pend_i_q <= cur;
					if (pend_q) begin
						o_last <= 1'b0;
						o_status <= bpfr_pkg::ST_OK;
						o_frame <= 4'(pend_i_q);
						o_load <= 1'b0;
						o_wb <= 1'b1;
						o_wpage <= page_q[pend_i_q];
						o_reads <= reads_q;
						o_writes <= writes_q;
					end
				end
			end
			if (cmd.flush_none) begin
				o_last <= 1'b1;
				o_status <= bpfr_pkg::ST_OK;
				o_load <= 1'b0;
				o_reads <= reads_q;
				o_writes <= writes_q;
				o_frame <= pend_q ? 4'(pend_i_q) : 4'd0;
				o_wb <= pend_q;
				o_wpage <= pend_q ? page_q[pend_i_q] : 31'd0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/buffer_pool_frame_replacer.sv =====
// A pin, unpin or dirty request scans the frame table one entry per cycle; a hit ends the scan
// at the hit frame, while a miss or an absent page scans all frames in use before out_valid shows.
// One request at a time: a new one is not accepted until the last result has been pushed,
// and output stalls delay it; a flush emits one word per dirty unpinned frame during its scan.
// Reset (arst_n low) empties all frames, clears pins, dirty marks, stamp and
// transfer counters, and sets policy to FIFO with 16 frames in use.
`default_nettype none
module buffer_pool_frame_replacer #(
	parameter int FRAMES   = 16,
	parameter int PIN_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  func,
	input  wire logic [30:0] page_num,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [3:0]       frame_index,
	output logic             load_request,
	output logic             write_back,
	output logic [30:0]      write_page,
	output logic [31:0]      reads_done,
	output logic [31:0]      writes_done,
	output logic             last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [4:0]  cfg_data
);
	logic policy_q;
	logic [4:0] frames_q;
	bpfr_pkg::cmd_t cmd;
	bpfr_pkg::sts_t sts;
	logic busy, in_go, out_free;
	logic p_push, p_load, p_wb, p_last;
	logic [1:0] p_status;
	logic [3:0] p_frame;
	logic [30:0] p_wpage;
	logic [31:0] p_reads, p_writes;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= 1'b0;
			frames_q <= 5'd16;
		end else if (cfg_valid) begin
			if (cfg_index == bpfr_pkg::CFG_POLICY) policy_q <= cfg_data[0];
			else frames_q <= cfg_data;
		end
	end

	assign in_stall = busy;
	assign in_go = in_valid && !busy;
	assign out_free = !out_valid || !out_stall;

	bpfr_ctrl u_ctrl (
		.clk, .arst_n, .in_go,
		.is_flush(func == bpfr_pkg::FUNC_FLUSH),
		.out_free, .sts, .cmd, .busy
	);

	bpfr_dp #(.FRAMES(FRAMES), .PIN_BITS(PIN_BITS)) u_dp (
		.clk, .arst_n, .cmd, .in_func(func), .in_page(page_num),
		.policy_mode(policy_q), .frames_in_use(frames_q), .sts,
		.o_push(p_push), .o_status(p_status), .o_frame(p_frame), .o_load(p_load),
		.o_wb(p_wb), .o_wpage(p_wpage), .o_reads(p_reads), .o_writes(p_writes),
		.o_last(p_last)
	);

	// datapath pushes only while out_free, so output slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (p_push) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end
	always_comb begin
		status = p_status;
		frame_index = p_frame;
		load_request = p_load;
		write_back = p_wb;
		write_page = p_wpage;
		reads_done = p_reads;
		writes_done = p_writes;
		last = p_last;
	end

	assert property (@(posedge clk) disable iff (!arst_n) out_valid && out_stall |=> out_valid)
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n) p_push |-> out_free)
		else $error("push overrun");
	assert property (@(posedge clk) disable iff (!arst_n) in_go |=> busy)
		else $error("accept without busy");
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none
module tb;
	typedef struct {
		logic [1:0]  f;
		logic [30:0] p;
	} request_t;

	typedef struct {
		logic [1:0]  status;
		logic [3:0]  frame;
		logic        load;
		logic        wb;
		logic [30:0] wpage;
		logic [31:0] rd;
		logic [31:0] wr;
		logic        last;
	} frame_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  func = bpfr_pkg::FUNC_PIN;
	logic [30:0] page_num = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [3:0]  frame_index;
	logic        load_request;
	logic        write_back;
	logic [30:0] write_page;
	logic [31:0] reads_done;
	logic [31:0] writes_done;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = bpfr_pkg::CFG_POLICY;
	logic [4:0]  cfg_data = '0;

	buffer_pool_frame_replacer uut (.*);

	always #10 clk = ~clk;

	request_t      req_queue[$];
	frame_result_t due_results[$];
	logic          word_taken = 1'b0;
	bit            noisy = 1'b1;
	bit            send_hold = 1'b0;
	int            hold_req = 0;
	int            hold_seen = 0;
	int            hold_cnt = 0;
	int            mismatches = 0;
	int            words_checked = 0;
	int            items_sent = 0;

	logic [30:0] res_page[16];
	bit          res_valid[16];
	logic [15:0] pins[16];
	bit          dirty[16];
	logic [31:0] stamp[16];
	logic [31:0] stamp_next;
	logic [31:0] loads_total;
	logic [31:0] writes_total;
	logic        lru_mode;
	logic [4:0]  frame_cfg;
	logic [30:0] page_pool[22];

	function automatic int active_count();
		return (frame_cfg > 16) ? 16 : int'(frame_cfg);
	endfunction

	function automatic logic [31:0] next_stamp();
		logic [31:0] s;
		s = stamp_next;
		if (stamp_next != 32'hFFFF_FFFF)
			stamp_next = stamp_next + 1;
		return s;
	endfunction

	task automatic push_word(logic [1:0] st, int fr, logic ld, logic wb,
			logic [30:0] wp, logic lst);
		frame_result_t r;
		r.status = st;
		r.frame = fr[3:0];
		r.load = ld;
		r.wb = wb;
		r.wpage = wp;
		r.rd = loads_total;
		r.wr = writes_total;
		r.last = lst;
		due_results.push_back(r);
	endtask

	task automatic load_frame(int i, logic [30:0] pg);
		res_page[i] = pg;
		res_valid[i] = 1;
		pins[i] = 1;
		dirty[i] = 0;
		stamp[i] = next_stamp();
		loads_total = loads_total + 1;
	endtask

	task automatic predict_request(logic [1:0] f, logic [30:0] pg);
		int n, hit, victim, k;
		logic [31:0] best;
		logic [30:0] old;
		n = active_count();
		hit = -1;
		victim = -1;
		best = '0;
		k = 0;
		for (int i = 0; i < n; i++)
			if (hit < 0 && res_valid[i] && res_page[i] == pg)
				hit = i;
		case (f)
			bpfr_pkg::FUNC_PIN: begin
				if (hit >= 0) begin
					if (pins[hit] != 16'hFFFF)
						pins[hit] = pins[hit] + 1;
					if (lru_mode)
						stamp[hit] = next_stamp();
					push_word(bpfr_pkg::ST_OK, hit, 0, 0, '0, 1);
					return;
				end
				for (int i = 0; i < n; i++)
					if (!res_valid[i]) begin
						load_frame(i, pg);
						push_word(bpfr_pkg::ST_OK, i, 1, 0, '0, 1);
						return;
					end
				for (int i = 0; i < n; i++)
					if (pins[i] == 0 && (victim < 0 || stamp[i] <= best)) begin
						best = stamp[i];
						victim = i;
					end
				if (victim < 0) begin
					push_word(bpfr_pkg::ST_FULL, 0, 0, 0, '0, 1);
					return;
				end
				old = dirty[victim] ? res_page[victim] : '0;
				if (dirty[victim])
					writes_total = writes_total + 1;
				k = dirty[victim];
				load_frame(victim, pg);
				push_word(bpfr_pkg::ST_OK, victim, 1, k[0], old, 1);
			end
			bpfr_pkg::FUNC_FLUSH: begin
				for (int i = 0; i < n; i++)
					if (res_valid[i] && dirty[i] && pins[i] == 0) begin
						dirty[i] = 0;
						writes_total = writes_total + 1;
						push_word(bpfr_pkg::ST_OK, i, 0, 1, res_page[i], 0);
						k++;
					end
				if (k == 0)
					push_word(bpfr_pkg::ST_OK, 0, 0, 0, '0, 1);
				else
					due_results[$].last = 1'b1;
			end
			default: begin
				if (hit < 0) begin
					push_word(bpfr_pkg::ST_NOT_HERE, 0, 0, 0, '0, 1);
					return;
				end
				if (f == bpfr_pkg::FUNC_UNPIN) begin
					if (pins[hit] > 0)
						pins[hit] = pins[hit] - 1;
				end else begin
					dirty[hit] = 1;
				end
				push_word(bpfr_pkg::ST_OK, hit, 0, 0, '0, 1);
			end
		endcase
	endtask

	always @(posedge clk) begin
		frame_result_t e;
		word_taken <= in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			predict_request(func, page_num);
			items_sent++;
		end
		if (arst_n && out_valid && !out_stall) begin
			words_checked++;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: status %0d frame %0d", status, frame_index);
			end else begin
				e = due_results.pop_front();
				if (status !== e.status || frame_index !== e.frame || load_request !== e.load
						|| write_back !== e.wb || write_page !== e.wpage
						|| reads_done !== e.rd || writes_done !== e.wr || last !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp st%0d fr%0d ld%0d wb%0d wp%h rd%0d wr%0d l%0d",
							" / got st%0d fr%0d ld%0d wb%0d wp%h rd%0d wr%0d l%0d"},
							e.status, e.frame, e.load, e.wb, e.wpage, e.rd, e.wr, e.last,
							status, frame_index, load_request, write_back, write_page,
							reads_done, writes_done, last);
				end
			end
		end
	end

	always @(negedge clk) begin
		request_t r;
		if (arst_n && (!in_valid || word_taken)) begin
			if (req_queue.size() > 0 && !send_hold && !(noisy && $urandom_range(99) < 20)) begin
				r = req_queue.pop_front();
				in_valid <= 1'b1;
				func <= r.f;
				page_num <= r.p;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_cnt <= 300;
			out_stall <= 1'b1;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= noisy && ($urandom_range(99) < 20);
		end
	end

	task automatic add_req(logic [1:0] f, logic [30:0] p);
		request_t r;
		r.f = f;
		r.p = p;
		req_queue.push_back(r);
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (req_queue.size() != 0 || in_valid || due_results.size() != 0);
		repeat (25) @(posedge clk);
	endtask

	task automatic cfg_write(logic [0:0] idx, logic [4:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		if (idx == bpfr_pkg::CFG_POLICY)
			lru_mode = val[0];
		else
			frame_cfg = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(int count);
		logic [30:0] p;
		int c;
		while (count > 0) begin
			p = page_pool[$urandom_range(21)];
			c = $urandom_range(99);
			if (c < 65) begin
				add_req(bpfr_pkg::FUNC_PIN, p);
				if ($urandom_range(1))
					add_req(bpfr_pkg::FUNC_DIRTY, p);
				if ($urandom_range(3) != 0)
					add_req(bpfr_pkg::FUNC_UNPIN, p);
				count -= 3;
			end else if (c < 80) begin
				add_req(bpfr_pkg::FUNC_FLUSH, 31'($urandom));
				count--;
			end else begin
				if ($urandom_range(1))
					p = 31'($urandom);
				add_req(2'($urandom_range(3)), p);
				count--;
			end
		end
	endtask

	initial begin
		for (int i = 0; i < 16; i++) begin
			res_valid[i] = 0;
			pins[i] = '0;
			dirty[i] = 0;
			res_page[i] = '0;
			stamp[i] = '0;
		end
		stamp_next = '0;
		loads_total = '0;
		writes_total = '0;
		lru_mode = 1'b0;
		frame_cfg = 5'd16;
		for (int i = 0; i < 20; i++)
			page_pool[i] = 31'($urandom);
		page_pool[20] = '0;
		page_pool[21] = 31'h7FFF_FFFF;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		cfg_write(bpfr_pkg::CFG_POLICY, 5'd0);
		cfg_write(bpfr_pkg::CFG_FRAMES, 5'd4);
		add_req(bpfr_pkg::FUNC_PIN, 31'h0);
		add_req(bpfr_pkg::FUNC_PIN, 31'h7FFF_FFFF);
		add_req(bpfr_pkg::FUNC_PIN, 31'h0);
		add_req(bpfr_pkg::FUNC_UNPIN, 31'h5);
		add_req(bpfr_pkg::FUNC_DIRTY, 31'h5);
		add_req(bpfr_pkg::FUNC_DIRTY, 31'h0);
		add_req(bpfr_pkg::FUNC_UNPIN, 31'h0);
		add_req(bpfr_pkg::FUNC_UNPIN, 31'h0);
		add_req(bpfr_pkg::FUNC_UNPIN, 31'h0);
		add_req(bpfr_pkg::FUNC_FLUSH, 31'h0);
		add_req(bpfr_pkg::FUNC_FLUSH, 31'h7FFF_FFFF);
		add_req(bpfr_pkg::FUNC_DIRTY, 31'h7FFF_FFFF);
		add_req(bpfr_pkg::FUNC_UNPIN, 31'h7FFF_FFFF);
		add_req(bpfr_pkg::FUNC_PIN, 31'h2AAA_AAAA);
		add_req(bpfr_pkg::FUNC_PIN, 31'h5555_5555);
		add_req(bpfr_pkg::FUNC_PIN, 31'h100);
		add_req(bpfr_pkg::FUNC_PIN, 31'h101);
		add_req(bpfr_pkg::FUNC_PIN, 31'h102);
		wait_drained();
		cfg_write(bpfr_pkg::CFG_FRAMES, 5'd0);
		add_req(bpfr_pkg::FUNC_PIN, 31'h3);
		add_req(bpfr_pkg::FUNC_UNPIN, 31'h0);
		add_req(bpfr_pkg::FUNC_DIRTY, 31'h0);
		add_req(bpfr_pkg::FUNC_FLUSH, 31'h0);
		wait_drained();
		cfg_write(bpfr_pkg::CFG_FRAMES, 5'd31);
		cfg_write(bpfr_pkg::CFG_POLICY, 5'd1);
		add_req(bpfr_pkg::FUNC_PIN, 31'h100);
		add_req(bpfr_pkg::FUNC_PIN, 31'h0);
		add_req(bpfr_pkg::FUNC_UNPIN, 31'h100);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			cfg_write(bpfr_pkg::CFG_POLICY, 5'($urandom_range(1)));
			cfg_write(bpfr_pkg::CFG_FRAMES, (ph == 0) ? 5'd1 : (ph == 1) ? 5'd16
				: 5'($urandom_range(2, 16)));
			noisy = (ph != 3);
			if (ph == 1)
				hold_req++;
			random_phase(15);
			if (ph == 2) begin
				send_hold = 1'b1;
				do @(posedge clk);
				while (in_valid || due_results.size() != 0);
				@(negedge clk);
				send_hold = 1'b0;
			end
			random_phase(15);
			wait_drained();
		end

		$display("Ran %0d requests, checked %0d result words, across FIFO/LRU and 0..31 frames.",
			items_sent, words_checked);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#6000000;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
src/bpfr_pkg.sv
src/bpfr_ctrl.sv
src/bpfr_dp.sv
src/buffer_pool_frame_replacer.sv
sim/tb.sv
